[design/psa_pkg.sv]
// ---------------------------------------------------------------------------
// psa_pkg: shared types and constants of the priority scheduler with aging
// Field widths, request kinds, stream packing sizes and the slot entry layout.
// ---------------------------------------------------------------------------
package psa_pkg;

    localparam int TIME_W       = 16;
    localparam int PRIO_W       = 4;
    localparam int AGE_W        = 3;
    localparam int SLOT_W       = 3;
    localparam int DEFAULT_SLOTS = 8;

    localparam logic [AGE_W-1:0] AGE_THR_RESET = 3'd5;
    localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;

    // request kinds carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
        logic [AGE_W-1:0]  age;
    } slot_entry_t;

endpackage

[design/preemptive_priority_scheduler_aging.sv]
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler_aging: preemptive priority scheduler with aging
// Holds a table of task slots and a time counter; a tick request runs the
// highest-priority ready slot for one unit and ages it.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: action; tdata: request
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: one result per request
//  cfg       | in        | cfg_we                      | cfg_wdata: age threshold
//
//  A tick request scans the slots in order from slot 0: the
//  scan reads one slot per cycle through the single read port of the slot
//  memory and one comparator judges each entry. A load request writes its slot if in range.
//  Reset clears the time counter and the per-slot work flags and loads the
//  default threshold; a slot whose work flag is clear is never chosen by a scan.
//  A stalled output holds the result register and the sequencer waits in its
//  final state; a new request is taken only while the sequencer is idle.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler_aging #(
    parameter int SLOTS = psa_pkg::DEFAULT_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tuser: action (0 load, 1 tick)
    input  logic                             s_axis_tuser,
    // tdata: slot[2:0], arrival[18:3], burst[34:19], prio[38:35], zero pad[39]
    input  logic [psa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: now[15:0], ran[16], ran_slot[19:17], finished[20], turnaround[36:21],
    //        waiting[52:37], all_done[53], zero pad[55:54]
    output logic [psa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [psa_pkg::AGE_W-1:0]        cfg_wdata
);

    import psa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPD,
        S_WAIT,
        S_FIN
    } state_t;

    // request fields
    logic              req_action;
    logic [SLOT_W-1:0] req_slot;
    logic [TIME_W-1:0] req_arrival;
    logic [TIME_W-1:0] req_burst;
    logic [PRIO_W-1:0] req_prio;

    assign req_action  = s_axis_tuser;
    assign req_slot    = s_axis_tdata[2:0];
    assign req_arrival = s_axis_tdata[18:3];
    assign req_burst   = s_axis_tdata[34:19];
    assign req_prio    = s_axis_tdata[38:35];

    // slot memory: one write port, one registered read port
    slot_entry_t       mem [SLOTS];
    slot_entry_t       rd_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_entry_t       mem_wdata;

    // control and result registers
    state_t            state_reg, state_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [AGE_W-1:0]  thr_reg, thr_next;
    logic [SLOTS-1:0]  live_reg, live_next;          // slot has work left
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  cand_idx_reg, cand_idx_next;  // slot of rd_data
    logic              cand_vld_reg, cand_vld_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    slot_entry_t       best_reg, best_next;
    logic              ran_reg, ran_next;
    logic              fin_reg, fin_next;
    logic [TIME_W-1:0] turn_reg, turn_next;
    logic [TIME_W-1:0] wait_reg, wait_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // working values
    logic              cand_ready;
    logic              take_cand;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] rem_dec;
    logic              load_ok;
    logic [IDX_W-1:0]  load_idx;
    logic              out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[scan_idx_reg];
    end

    // judge the entry that arrived from memory this cycle
    assign cand_ready = cand_vld_reg && live_reg[cand_idx_reg] && (rd_data.arrival <= time_reg);
    assign take_cand  = cand_ready && (!found_reg || (rd_data.prio > best_reg.prio));

    assign time_inc = (time_reg == TIME_MAX) ? time_reg : time_reg + 16'd1;
    assign rem_dec  = best_reg.remaining - 16'd1;
    assign load_ok  = (32'(req_slot) < SLOTS);
    assign load_idx = IDX_W'(req_slot);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        time_next     = time_reg;
        thr_next      = thr_reg;
        live_next     = live_reg;
        scan_idx_next = scan_idx_reg;
        cand_idx_next = scan_idx_reg;
        cand_vld_next = 1'b0;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        ran_next      = ran_reg;
        fin_next      = fin_reg;
        turn_next     = turn_reg;
        wait_next     = wait_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = load_idx;
        mem_wdata     = '0;

        if (cfg_we)
        begin
            thr_next = cfg_wdata;
        end

        // drain the output register
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        // evaluate the scanned candidate
        if (take_cand)
        begin
            found_next    = 1'b1;
            best_idx_next = cand_idx_reg;
            best_next     = rd_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                ran_next  = 1'b0;
                fin_next  = 1'b0;
                turn_next = '0;
                wait_next = '0;
                if (s_axis_tvalid)
                begin
                    if (req_action == ACT_LOAD)
                    begin
                        if (load_ok)
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.arrival   = req_arrival;
                            mem_wdata.burst     = req_burst;
                            mem_wdata.remaining = req_burst;
                            mem_wdata.prio      = req_prio;
                            mem_wdata.age       = '0;
                            live_next[load_idx] = (req_burst != '0);
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, candidate follows in the next cycle
                cand_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_LAST:
            begin
                if (found_next)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    time_next  = time_inc;
                    state_next = S_FIN;
                end
            end

            S_UPD:
            begin
                // run the chosen slot one unit, age it, write it back
                mem_we              = 1'b1;
                mem_waddr           = best_idx_reg;
                mem_wdata           = best_reg;
                mem_wdata.remaining = rem_dec;
                if (best_reg.age >= thr_reg)
                begin
                    if (best_reg.prio != '0)
                    begin
                        mem_wdata.prio = best_reg.prio - 1'b1;
                    end
                    mem_wdata.age = '0;
                end
                else
                begin
                    mem_wdata.age = best_reg.age + 1'b1;
                end
                live_next[best_idx_reg] = (rem_dec != '0);
                time_next = time_inc;
                ran_next  = 1'b1;
                fin_next  = (rem_dec == '0);
                turn_next = (rem_dec == '0) ? (time_inc - best_reg.arrival) : '0;
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                // waiting clamps at zero once time has saturated
                if (fin_reg && (turn_reg >= best_reg.burst))
                begin
                    wait_next = turn_reg - best_reg.burst;
                end
                else
                begin
                    wait_next = '0;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, ~|live_reg, wait_reg, turn_reg, fin_reg,
                                    (ran_reg ? SLOT_W'(best_idx_reg) : {SLOT_W{1'b0}}),
                                    ran_reg, time_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            time_reg     <= '0;
            thr_reg      <= AGE_THR_RESET;
            live_reg     <= '0;
            scan_idx_reg <= '0;
            cand_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            time_reg     <= time_next;
            thr_reg      <= thr_next;
            live_reg     <= live_next;
            scan_idx_reg <= scan_idx_next;
            cand_vld_reg <= cand_vld_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cand_idx_reg <= cand_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        ran_reg      <= ran_next;
        fin_reg      <= fin_next;
        turn_reg     <= turn_next;
        wait_reg     <= wait_next;
        m_data_reg   <= m_data_next;
    end

endmodule
